/* rtl/core/smhr_pkg.sv */
// Shared types and constants for the stack with middle read and half reverse.
package smhr_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int FILL_W          = 5;
    localparam int CODE_W          = 2;
    localparam int IN_TDATA_W      = 32;
    localparam int OUT_TDATA_W     = 40;

    typedef enum logic [CODE_W-1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_MID  = 2'd2,
        KIND_REV  = 2'd3
    } kind_t;

    typedef enum logic [CODE_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FEW   = 2'd3
    } status_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  data;
        logic [FILL_W-1:0]         fill;
    } result_t;

endpackage

/* rtl/core/smhr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module smhr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/stack_with_middle_and_half_reverse.sv */
// Stack top level: command decode, entry count, reverse sequencer and result queue.
// Push and every refused command register their result into the result queue; pop and middle
// read the entry RAM (registered read data) and answer from S_READ. Reverse answers directly
// when nothing moves, else after floor(count/4) swaps through S_RD_LO, S_RD_HI, S_WR_LO, S_WR_HI
// on the single RAM port pair. New beats wait while pop, middle or reverse runs or skid_reg is in use.
// Reset clears the entry count and the result queue at once; the entry RAM is not cleared.
module stack_with_middle_and_half_reverse #(
    parameter int STACK_DEPTH = smhr_pkg::STACK_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [smhr_pkg::IN_TDATA_W-1:0]  s_tdata,  // [31:0] push_value
    input  logic [smhr_pkg::CODE_W-1:0]      s_tuser,  // [1:0] kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [smhr_pkg::OUT_TDATA_W-1:0] m_tdata,  // [31:0] data_out, [36:32] fill_count
    output logic [smhr_pkg::CODE_W-1:0]      m_tuser   // [1:0] status
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RD_LO,
        S_RD_HI,
        S_WR_LO,
        S_WR_HI
    } state_t;

    state_t                            state_reg, state_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [ADDR_W-1:0]                 lo_reg, lo_next;
    logic [ADDR_W-1:0]                 hi_reg, hi_next;
    logic [smhr_pkg::DATA_W-1:0]       tmp_reg;
    smhr_pkg::result_t                 out_reg, skid_reg;
    logic                              out_v_reg, skid_v_reg;

    logic                              accept;
    logic                              slot_free;
    logic                              prod_v;
    smhr_pkg::result_t                 prod;
    smhr_pkg::kind_t                   kind;
    logic                              full;
    logic                              empty;
    logic [CNT_W-1:0]                  cnt_m1;
    logic [CNT_W-1:0]                  half;

    logic                              ram_we;
    logic [ADDR_W-1:0]                 ram_waddr;
    logic [smhr_pkg::DATA_W-1:0]       ram_wdata;
    logic [ADDR_W-1:0]                 ram_raddr;
    logic [smhr_pkg::DATA_W-1:0]       ram_rdata;

    smhr_ram #(
        .WIDTH (smhr_pkg::DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE) && !skid_v_reg;
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_v_reg || m_tready;
    assign kind      = smhr_pkg::kind_t'(s_tuser);
    assign full      = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty     = (count_reg == '0);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign half      = count_reg >> 1;

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.fill, out_reg.data};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        ram_we      = 1'b0;
        ram_waddr   = lo_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = lo_reg;
        prod_v      = 1'b0;
        prod.status = smhr_pkg::ST_OK;
        prod.data   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        smhr_pkg::KIND_PUSH:
                        begin
                            prod_v = 1'b1;
                            if (full)
                            begin
                                prod.status = smhr_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[ADDR_W-1:0];
                                ram_wdata  = s_tdata[smhr_pkg::DATA_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        smhr_pkg::KIND_POP:
                        begin
                            if (empty)
                            begin
                                prod_v      = 1'b1;
                                prod.status = smhr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = cnt_m1[ADDR_W-1:0];
                                count_next = cnt_m1;
                                state_next = S_READ;
                            end
                        end
                        smhr_pkg::KIND_MID:
                        begin
                            if (empty)
                            begin
                                prod_v      = 1'b1;
                                prod.status = smhr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = ADDR_W'(cnt_m1 >> 1);
                                state_next = S_READ;
                            end
                        end
                        smhr_pkg::KIND_REV:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                prod_v      = 1'b1;
                                prod.status = smhr_pkg::ST_FEW;
                            end
                            else if (half < CNT_W'(2))
                            begin
                                // single-entry half: nothing moves
                                prod_v = 1'b1;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = ADDR_W'(half - CNT_W'(1));
                                state_next = S_RD_LO;
                            end
                        end
                        default:
                        begin
                            prod_v = 1'b0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                prod_v     = 1'b1;
                prod.data  = ram_rdata;
                state_next = S_IDLE;
            end
            S_RD_LO:
            begin
                ram_raddr  = lo_reg;
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                ram_raddr  = hi_reg;
                state_next = S_WR_LO;
            end
            S_WR_LO:
            begin
                // rdata now holds the upper entry
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = ram_rdata;
                state_next = S_WR_HI;
            end
            S_WR_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = tmp_reg;
                lo_next   = lo_reg + ADDR_W'(1);
                hi_next   = hi_reg - ADDR_W'(1);
                if ((lo_reg + ADDR_W'(1)) < (hi_reg - ADDR_W'(1)))
                begin
                    state_next = S_RD_LO;
                end
                else
                begin
                    prod_v     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        prod.fill = smhr_pkg::FILL_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;

            // two-entry result queue: out_reg drives the port, skid_reg catches overflow
            if (slot_free)
            begin
                if (skid_v_reg)
                begin
                    out_reg   <= skid_reg;
                    out_v_reg <= 1'b1;
                    if (prod_v)
                    begin
                        skid_reg <= prod;
                    end
                    else
                    begin
                        skid_v_reg <= 1'b0;
                    end
                end
                else
                begin
                    out_v_reg <= prod_v;
                    if (prod_v)
                    begin
                        out_reg <= prod;
                    end
                end
            end
            else if (prod_v)
            begin
                skid_reg   <= prod;
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        // hold the lower entry of the swap pair
        if (state_reg == S_RD_HI)
        begin
            tmp_reg <= ram_rdata;
        end
    end

endmodule
